// File: sv/rlps_pkg.sv
`default_nettype none

package rlps_pkg;

  typedef logic [3:0] mode_t;
  typedef logic [6:0] level_t;
  typedef logic [9:0] duty_t;

  localparam mode_t MODE_WHITE    = 4'd1;
  localparam mode_t MODE_BLUE     = 4'd2;
  localparam mode_t MODE_RED      = 4'd3;
  localparam mode_t MODE_GREEN    = 4'd4;
  localparam mode_t MODE_CYAN     = 4'd5;
  localparam mode_t MODE_MAGENTA  = 4'd6;
  localparam mode_t MODE_YELLOW   = 4'd7;
  localparam mode_t MODE_FLASH    = 4'd8;
  localparam mode_t MODE_CHASE    = 4'd9;
  localparam mode_t MODE_FADE     = 4'd10;
  localparam mode_t MODE_XFADE    = 4'd11;
  localparam mode_t MODE_ALT_YM   = 4'd12;
  localparam mode_t MODE_ALT_YC   = 4'd13;
  localparam mode_t MODE_ALT_CM   = 4'd14;

  localparam int unsigned LVL_RECIP    = 205;
  localparam int unsigned LVL_SHIFT    = 11;
  localparam int unsigned BRIGHT_MUL   = 1017819;
  localparam int unsigned BRIGHT_SHIFT = 20;
  localparam int unsigned PAUSE_RECIP  = 41121;
  localparam int unsigned PAUSE_SHIFT  = 22;
  localparam int unsigned DUTY_SCALE   = 10;
  localparam level_t      LEVEL_FULL   = 7'd100;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [8:0]  PAUSE_MIN_RST = 9'd10;
  localparam logic [8:0]  PAUSE_MAX_RST = 9'd500;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_PAUSE_MIN = 2'd1,
    CFG_PAUSE_MAX = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [8:0]  pause_min;
    logic [8:0]  pause_max;
  } cfg_t;

  typedef struct packed {
    logic       button_edge;
    logic       button_level;
    logic       adc_valid;
    logic [9:0] adc_value;
  } in_word_t;

  typedef struct packed {
    duty_t red_duty;
    duty_t green_duty;
    duty_t blue_duty;
    mode_t light_mode;
  } out_word_t;

  typedef struct packed {
    logic        button_edge;
    logic        button_level;
    logic        adc_valid;
    level_t      lvl;
    level_t      bright;
    logic        prod_neg;
    logic [15:0] prod_mag;
  } knob_t;

  typedef struct packed {
    level_t r;
    level_t g;
    level_t b;
  } rgb_t;

  function automatic logic is_pattern(mode_t m);
    return (m >= MODE_FLASH) && (m <= MODE_ALT_CM);
  endfunction

  function automatic level_t pass_len(mode_t m);
    case (m)
      MODE_CHASE: return 7'd3;
      MODE_FADE:  return 7'd120;
      MODE_XFADE: return 7'd60;
      default:    return 7'd2;
    endcase
  endfunction

  function automatic rgb_t static_levels(mode_t m, level_t br);
    rgb_t lv;
    lv = '0;
    case (m)
      MODE_WHITE:   lv = '{r: br, g: br, b: br};
      MODE_BLUE:    lv.b = br;
      MODE_RED:     lv.r = br;
      MODE_GREEN:   lv.g = br;
      MODE_CYAN:    begin lv.b = br; lv.g = br; end
      MODE_MAGENTA: begin lv.b = br; lv.r = br; end
      MODE_YELLOW:  begin lv.r = br; lv.g = br; end
      default:      lv = '0;
    endcase
    return lv;
  endfunction

  function automatic rgb_t pattern_levels(mode_t m, level_t idx);
    rgb_t       lv;
    logic [1:0] ph;
    level_t     k;
    logic [7:0] up;
    logic [7:0] dn;
    lv = '0;
    ph = 2'd0;
    k  = '0;
    up = '0;
    dn = '0;
    case (m)
      MODE_FLASH: begin
        if (idx == 7'd0) lv = '{r: LEVEL_FULL, g: LEVEL_FULL, b: LEVEL_FULL};
      end
      MODE_CHASE: begin
        if (idx == 7'd0) lv.g = LEVEL_FULL;
        else if (idx == 7'd1) lv.r = LEVEL_FULL;
        else lv.b = LEVEL_FULL;
      end
      MODE_FADE: begin
        if (idx >= 7'd80) begin
          ph = 2'd2; k = idx - 7'd80;
        end else if (idx >= 7'd40) begin
          ph = 2'd1; k = idx - 7'd40;
        end else begin
          ph = 2'd0; k = idx;
        end
        if (k < 7'd20) up = 8'(k) * 8'd5;
        else up = 8'd100 - (8'(k) - 8'd20) * 8'd5;
        if (ph == 2'd0) lv.g = up[6:0];
        else if (ph == 2'd1) lv.r = up[6:0];
        else lv.b = up[6:0];
      end
      MODE_XFADE: begin
        if (idx >= 7'd40) begin
          ph = 2'd2; k = idx - 7'd40;
        end else if (idx >= 7'd20) begin
          ph = 2'd1; k = idx - 7'd20;
        end else begin
          ph = 2'd0; k = idx;
        end
        up = 8'(k) * 8'd5;
        dn = 8'd95 - up;
        if (ph == 2'd0) begin
          lv.r = dn[6:0]; lv.b = up[6:0];
        end else if (ph == 2'd1) begin
          lv.b = dn[6:0]; lv.g = up[6:0];
        end else begin
          lv.g = dn[6:0]; lv.r = up[6:0];
        end
      end
      MODE_ALT_YM: begin
        if (idx == 7'd0) begin lv.g = LEVEL_FULL; lv.r = LEVEL_FULL; end
        else begin lv.r = LEVEL_FULL; lv.b = LEVEL_FULL; end
      end
      MODE_ALT_YC: begin
        if (idx == 7'd0) begin lv.g = LEVEL_FULL; lv.r = LEVEL_FULL; end
        else begin lv.g = LEVEL_FULL; lv.b = LEVEL_FULL; end
      end
      MODE_ALT_CM: begin
        if (idx == 7'd0) begin lv.g = LEVEL_FULL; lv.b = LEVEL_FULL; end
        else begin lv.r = LEVEL_FULL; lv.b = LEVEL_FULL; end
      end
      default: lv = '0;
    endcase
    return lv;
  endfunction

endpackage

`default_nettype wire

// File: sv/rlps_knob.sv
`default_nettype none

module rlps_knob (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rlps_pkg::cfg_t    cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rlps_pkg::in_word_t in_word_i,
  output logic                   knob_valid_o,
  input  wire logic              knob_stall_i,
  output rlps_pkg::knob_t        knob_o
);

  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready;

  logic                  s1_edge_q, s1_level_q, s1_adc_q;
  rlps_pkg::level_t      s1_lvl_q;
  rlps_pkg::knob_t       s2_q;

  logic [17:0]           lvl_prod;
  logic [26:0]           bright_prod;
  logic signed [9:0]     span;
  logic signed [17:0]    pause_prod;
  logic [17:0]           pause_mag;

  assign s2_ready   = !s2_valid_q || !knob_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  assign lvl_prod    = 18'(in_word_i.adc_value) * 18'(rlps_pkg::LVL_RECIP);
  assign bright_prod = 27'(s1_lvl_q) * 27'(rlps_pkg::BRIGHT_MUL);
  assign span        = $signed({1'b0, cfg_i.pause_max}) - $signed({1'b0, cfg_i.pause_min});
  assign pause_prod  = $signed({11'b0, s1_lvl_q}) * 18'(span);
  assign pause_mag   = pause_prod[17] ? 18'(-pause_prod) : 18'(pause_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_edge_q  <= in_word_i.button_edge;
      s1_level_q <= in_word_i.button_level;
      s1_adc_q   <= in_word_i.adc_valid;
      s1_lvl_q   <= lvl_prod[rlps_pkg::LVL_SHIFT +: 7];
    end
    if (s2_ready && s1_valid_q) begin
      s2_q.button_edge  <= s1_edge_q;
      s2_q.button_level <= s1_level_q;
      s2_q.adc_valid    <= s1_adc_q;
      s2_q.lvl          <= s1_lvl_q;
      s2_q.bright       <= bright_prod[rlps_pkg::BRIGHT_SHIFT +: 7] + 7'd1;
      s2_q.prod_neg     <= pause_prod[17];
      s2_q.prod_mag     <= pause_mag[15:0];
    end
  end

  assign knob_valid_o = s2_valid_q;
  assign knob_o       = s2_q;

endmodule

`default_nettype wire

// File: sv/rlps_seq.sv
`default_nettype none

module rlps_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rlps_pkg::cfg_t      cfg_i,
  input  wire logic                knob_valid_i,
  output logic                     knob_stall_o,
  input  wire rlps_pkg::knob_t     knob_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rlps_pkg::out_word_t      out_word_o
);

  logic take;
  logic out_valid_q, out_valid_d;

  rlps_pkg::mode_t  mode_q, mode_d;
  rlps_pkg::level_t step_q, step_d;
  logic [8:0]       wait_q, wait_d;
  logic [8:0]       ppause_q, ppause_d;
  logic             skip_q, skip_d;
  logic             pend_q, pend_d;
  logic [15:0]      tick_q, tick_d;
  logic [15:0]      last_q, last_d;
  rlps_pkg::level_t prev_q, prev_d;
  rlps_pkg::level_t bright_q, bright_d;
  logic [8:0]       kpause_q, kpause_d;
  rlps_pkg::duty_t  red_q, red_d, green_q, green_d, blue_q, blue_d;

  logic [31:0]      quot_prod;
  logic [8:0]       quot;
  logic [8:0]       knob_pause;
  logic [15:0]      elapsed;

  assign knob_stall_o = out_valid_q && out_stall_i;
  assign take         = knob_valid_i && !knob_stall_o;
  assign out_valid_d  = take ? 1'b1 : (out_valid_q && out_stall_i);

  assign quot_prod  = 32'(knob_i.prod_mag) * 32'(rlps_pkg::PAUSE_RECIP);
  assign quot       = quot_prod[rlps_pkg::PAUSE_SHIFT +: 9];
  assign knob_pause = cfg_i.pause_min + (knob_i.prod_neg ? 9'(-quot) : quot);
  assign elapsed    = tick_d - last_q;

  always_comb begin
    rlps_pkg::rgb_t lv;
    logic           pat;
    lv       = '0;
    pat      = rlps_pkg::is_pattern(mode_q);
    tick_d   = tick_q + 16'd1;
    skip_d   = skip_q;
    pend_d   = pend_q;
    bright_d = bright_q;
    kpause_d = kpause_q;
    prev_d   = prev_q;
    mode_d   = mode_q;
    step_d   = step_q;
    wait_d   = wait_q;
    ppause_d = ppause_q;
    last_d   = last_q;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;

    if (knob_i.button_edge) begin
      pend_d = 1'b1;
      skip_d = 1'b1;
    end
    if (knob_i.adc_valid) begin
      bright_d = knob_i.bright;
      kpause_d = knob_pause;
      if (knob_i.lvl != prev_q) begin
        skip_d = 1'b1;
        prev_d = knob_i.lvl;
      end else begin
        skip_d = 1'b0;
      end
    end

    if (pat && (wait_q > 9'd1) && !skip_d) begin
      wait_d = wait_q - 9'd1;
    end else begin
      wait_d = '0;
      if (!pat || (step_q == 7'd0)) begin
        if (pend_d && (elapsed > cfg_i.debounce_ms)) begin
          if (knob_i.button_level) begin
            pend_d = 1'b0;
            skip_d = 1'b0;
            mode_d = ((mode_q >= rlps_pkg::MODE_ALT_CM) || (mode_q == 4'd0)) ?
                     rlps_pkg::MODE_WHITE : mode_q + 4'd1;
          end
          last_d = tick_d;
        end
        step_d = '0;
        if (rlps_pkg::is_pattern(mode_d)) ppause_d = kpause_d;
      end
      if (rlps_pkg::is_pattern(mode_d)) begin
        if (step_d >= rlps_pkg::pass_len(mode_d)) step_d = '0;
        lv     = rlps_pkg::pattern_levels(mode_d, step_d);
        step_d = step_d + 7'd1;
        if (step_d >= rlps_pkg::pass_len(mode_d)) step_d = '0;
        wait_d = skip_d ? 9'd0 : ppause_d;
      end else begin
        lv = rlps_pkg::static_levels(mode_d, bright_d);
      end
      red_d   = 10'(lv.r) * 10'(rlps_pkg::DUTY_SCALE);
      green_d = 10'(lv.g) * 10'(rlps_pkg::DUTY_SCALE);
      blue_d  = 10'(lv.b) * 10'(rlps_pkg::DUTY_SCALE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= rlps_pkg::MODE_WHITE;
      step_q      <= '0;
      wait_q      <= '0;
      ppause_q    <= '0;
      skip_q      <= 1'b0;
      pend_q      <= 1'b0;
      tick_q      <= '0;
      last_q      <= '0;
      prev_q      <= '0;
      bright_q    <= '0;
      kpause_q    <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        mode_q   <= mode_d;
        step_q   <= step_d;
        wait_q   <= wait_d;
        ppause_q <= ppause_d;
        skip_q   <= skip_d;
        pend_q   <= pend_d;
        tick_q   <= tick_d;
        last_q   <= last_d;
        prev_q   <= prev_d;
        bright_q <= bright_d;
        kpause_q <= kpause_d;
        red_q    <= red_d;
        green_q  <= green_d;
        blue_q   <= blue_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = '{red_duty: red_q, green_duty: green_q, blue_duty: blue_q,
                         light_mode: mode_q};

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q >= rlps_pkg::MODE_WHITE) && (mode_q <= rlps_pkg::MODE_ALT_CM))
    else $error("mode out of range");

  a_static_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rlps_pkg::is_pattern(mode_q) |-> (wait_q == 9'd0) && (step_q == 7'd0))
    else $error("static mode left a wait or step pending");

  a_step_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rlps_pkg::is_pattern(mode_q) |-> (step_q < rlps_pkg::pass_len(mode_q)))
    else $error("step index past end of pass");

  a_press_clear_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) |-> (mode_q != $past(mode_q)))
    else $error("press cleared without mode advance");

  a_duty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (red_q <= 10'd1000) && (green_q <= 10'd1000) && (blue_q <= 10'd1000))
    else $error("duty above period");

endmodule

`default_nettype wire

// File: sv/rgb_light_pattern_sequencer.sv
`default_nettype none

// RGB light pattern sequencer. Each input word is one millisecond tick carrying the
// button falling edge, the button level and an optional 10-bit knob sample; each tick
// yields exactly one output word with the red, green and blue PWM duties (0..1000)
// and the current mode (1..14). A word passes from input to output through two
// knob stages (sample scaling, then the brightness and pause products) and the
// sequencer stage, which loads the output register. One word is accepted per cycle
// whenever the output side keeps up; the pipeline stages fill bubbles while the output
// is stalled. Registers (to be written only while idle; the block does not enforce
// this): 0 debounce ticks, 1 minimum pause, 2 maximum pause.
module rgb_light_pattern_sequencer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire rlps_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output rlps_pkg::out_word_t       out_word_o
);

  rlps_pkg::cfg_t  cfg_q;
  logic            knob_valid;
  logic            knob_stall;
  rlps_pkg::knob_t knob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= rlps_pkg::DEBOUNCE_RST;
      cfg_q.pause_min   <= rlps_pkg::PAUSE_MIN_RST;
      cfg_q.pause_max   <= rlps_pkg::PAUSE_MAX_RST;
    end else if (cfg_we_i) begin
      case (rlps_pkg::cfg_idx_e'(cfg_idx_i))
        rlps_pkg::CFG_DEBOUNCE:  cfg_q.debounce_ms <= cfg_data_i;
        rlps_pkg::CFG_PAUSE_MIN: cfg_q.pause_min   <= cfg_data_i[8:0];
        rlps_pkg::CFG_PAUSE_MAX: cfg_q.pause_max   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  rlps_knob u_knob (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .knob_valid_o (knob_valid),
    .knob_stall_i (knob_stall),
    .knob_o       (knob)
  );

  rlps_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .knob_valid_i (knob_valid),
    .knob_stall_o (knob_stall),
    .knob_i       (knob),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;

  localparam int QUIET_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int FULL_LEVEL     = 100;
  localparam int DUTY_PER_LEVEL = 10;
  localparam int IDLE_PCT       = 18;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [1:0]          cfg_idx_i  = rlps_pkg::CFG_DEBOUNCE;
  logic [15:0]         cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  rlps_pkg::in_word_t  in_word_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rlps_pkg::out_word_t out_word_o;

  rgb_light_pattern_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sequencer state as predicted
  logic [15:0]     debounce_cfg;
  logic [8:0]      pause_lo_cfg;
  logic [8:0]      pause_hi_cfg;
  rlps_pkg::mode_t cur_mode;
  logic [6:0]      step_idx;
  logic [8:0]      hold_ticks;
  logic [8:0]      pass_pause;
  logic            skip;
  logic            press_pending;
  logic [15:0]     ticks;
  logic [15:0]     last_check;
  logic [6:0]      last_level;
  logic [6:0]      brightness;
  logic [8:0]      knob_pause;
  rlps_pkg::duty_t duty_r;
  rlps_pkg::duty_t duty_g;
  rlps_pkg::duty_t duty_b;

  rlps_pkg::out_word_t expected_lights[$];
  int          mismatches      = 0;
  int          quiet_cycles    = 0;
  int          hold_off_left   = 0;
  bit          steady          = 1'b0;
  int          button_low_left = 0;
  int          knob_value      = 0;

  function automatic bit is_pattern_mode(rlps_pkg::mode_t m);
    return (m >= rlps_pkg::MODE_FLASH) && (m <= rlps_pkg::MODE_ALT_CM);
  endfunction

  function automatic int steps_in_pass(rlps_pkg::mode_t m);
    case (m)
      rlps_pkg::MODE_CHASE: return 3;
      rlps_pkg::MODE_FADE:  return 120;
      rlps_pkg::MODE_XFADE: return 60;
      default:              return 2;
    endcase
  endfunction

  function automatic void pattern_mix(input rlps_pkg::mode_t m, input int idx,
                                      output int r, output int g, output int b);
    int ph;
    int k;
    int up;
    int dn;
    r = 0;
    g = 0;
    b = 0;
    case (m)
      rlps_pkg::MODE_FLASH: begin
        if (idx == 0) begin r = FULL_LEVEL; g = FULL_LEVEL; b = FULL_LEVEL; end
      end
      rlps_pkg::MODE_CHASE: begin
        if (idx == 0) g = FULL_LEVEL;
        else if (idx == 1) r = FULL_LEVEL;
        else b = FULL_LEVEL;
      end
      rlps_pkg::MODE_FADE: begin
        ph = idx / 40;
        k  = idx % 40;
        up = (k < 20) ? 5 * k : FULL_LEVEL - 5 * (k - 20);
        if (ph == 0) g = up;
        else if (ph == 1) r = up;
        else b = up;
      end
      rlps_pkg::MODE_XFADE: begin
        ph = idx / 20;
        k  = idx % 20;
        up = 5 * k;
        dn = 95 - 5 * k;
        if (ph == 0) begin r = dn; b = up; end
        else if (ph == 1) begin b = dn; g = up; end
        else begin g = dn; r = up; end
      end
      rlps_pkg::MODE_ALT_YM: begin
        if (idx == 0) begin g = FULL_LEVEL; r = FULL_LEVEL; end
        else begin r = FULL_LEVEL; b = FULL_LEVEL; end
      end
      rlps_pkg::MODE_ALT_YC: begin
        if (idx == 0) begin g = FULL_LEVEL; r = FULL_LEVEL; end
        else begin g = FULL_LEVEL; b = FULL_LEVEL; end
      end
      default: begin
        if (idx == 0) begin g = FULL_LEVEL; b = FULL_LEVEL; end
        else begin r = FULL_LEVEL; b = FULL_LEVEL; end
      end
    endcase
  endfunction

  function automatic void reset_sequencer();
    debounce_cfg  = rlps_pkg::DEBOUNCE_RST;
    pause_lo_cfg  = rlps_pkg::PAUSE_MIN_RST;
    pause_hi_cfg  = rlps_pkg::PAUSE_MAX_RST;
    cur_mode      = rlps_pkg::MODE_WHITE;
    step_idx      = '0;
    hold_ticks    = '0;
    pass_pause    = '0;
    skip          = 1'b0;
    press_pending = 1'b0;
    ticks         = '0;
    last_check    = '0;
    last_level    = '0;
    brightness    = '0;
    knob_pause    = '0;
    duty_r        = '0;
    duty_g        = '0;
    duty_b        = '0;
  endfunction

  function automatic rlps_pkg::out_word_t predict_tick(rlps_pkg::in_word_t w);
    int          lvl;
    int          span;
    int          r;
    int          g;
    int          b;
    logic [15:0] gap;
    r = 0;
    g = 0;
    b = 0;
    ticks = ticks + 16'd1;
    if (w.button_edge) begin
      press_pending = 1'b1;
      skip = 1'b1;
    end
    if (w.adc_valid) begin
      lvl = int'(w.adc_value) / 10;
      span = int'(pause_hi_cfg) - int'(pause_lo_cfg);
      brightness = 7'(lvl * 99 / 102 + 1);
      knob_pause = 9'(lvl * span / 102 + int'(pause_lo_cfg));
      if (7'(lvl) != last_level) begin
        skip = 1'b1;
        last_level = 7'(lvl);
      end else begin
        skip = 1'b0;
      end
    end
    if (is_pattern_mode(cur_mode) && hold_ticks > 9'd1 && !skip) begin
      hold_ticks = hold_ticks - 9'd1;
    end else begin
      hold_ticks = '0;
      if (!is_pattern_mode(cur_mode) || step_idx == 7'd0) begin
        gap = ticks - last_check;
        if (press_pending && gap > debounce_cfg) begin
          if (w.button_level) begin
            duty_r = '0;
            duty_g = '0;
            duty_b = '0;
            press_pending = 1'b0;
            skip = 1'b0;
            cur_mode = (cur_mode >= rlps_pkg::MODE_ALT_CM || cur_mode == 4'd0) ?
                       rlps_pkg::MODE_WHITE : cur_mode + 4'd1;
          end
          last_check = ticks;
        end
        step_idx = '0;
        if (is_pattern_mode(cur_mode)) pass_pause = knob_pause;
      end
      if (is_pattern_mode(cur_mode)) begin
        if (int'(step_idx) >= steps_in_pass(cur_mode)) step_idx = '0;
        pattern_mix(cur_mode, int'(step_idx), r, g, b);
        step_idx = step_idx + 7'd1;
        if (int'(step_idx) >= steps_in_pass(cur_mode)) step_idx = '0;
        hold_ticks = skip ? 9'd0 : pass_pause;
      end else begin
        case (cur_mode)
          rlps_pkg::MODE_WHITE:   begin r = brightness; g = brightness; b = brightness; end
          rlps_pkg::MODE_BLUE:    b = brightness;
          rlps_pkg::MODE_RED:     r = brightness;
          rlps_pkg::MODE_GREEN:   g = brightness;
          rlps_pkg::MODE_CYAN:    begin b = brightness; g = brightness; end
          rlps_pkg::MODE_MAGENTA: begin b = brightness; r = brightness; end
          rlps_pkg::MODE_YELLOW:  begin r = brightness; g = brightness; end
          default: ;
        endcase
      end
      duty_r = rlps_pkg::duty_t'(r * DUTY_PER_LEVEL);
      duty_g = rlps_pkg::duty_t'(g * DUTY_PER_LEVEL);
      duty_b = rlps_pkg::duty_t'(b * DUTY_PER_LEVEL);
    end
    return '{red_duty: duty_r, green_duty: duty_g, blue_duty: duty_b, light_mode: cur_mode};
  endfunction

  function automatic rlps_pkg::in_word_t make_word(bit btn_fall, bit btn_high, bit sample,
                                                   int value);
    rlps_pkg::in_word_t w;
    w.button_edge  = btn_fall;
    w.button_level = btn_high;
    w.adc_valid    = sample;
    w.adc_value    = 10'(value);
    return w;
  endfunction

  // presses hold the button low a few ticks; knob mostly jitters in its bucket
  function automatic rlps_pkg::in_word_t random_tick(int press_pct);
    rlps_pkg::in_word_t w;
    int                 pick;
    int                 v;
    w.adc_valid = 1'b0;
    w.adc_value = 10'($urandom_range(0, 1023));
    if (button_low_left > 0) begin
      w.button_edge  = 1'b0;
      w.button_level = 1'b0;
      button_low_left--;
    end else if ($urandom_range(0, 99) < press_pct) begin
      w.button_edge  = 1'b1;
      w.button_level = 1'b0;
      button_low_left = $urandom_range(0, 3);
    end else begin
      w.button_edge  = 1'b0;
      w.button_level = 1'b1;
    end
    if ($urandom_range(0, 99) < 4) begin
      w.button_edge  = 1'($urandom_range(0, 1));
      w.button_level = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 99) < 20) begin
      w.adc_valid = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        v = (knob_value / 10) * 10 + $urandom_range(0, 9);
        if (v > 1023) v = 1023;
      end else if (pick < 65) begin
        knob_value = $urandom_range(0, 1) ? 1023 : 0;
        v = knob_value;
      end else begin
        knob_value = $urandom_range(0, 1023);
        v = knob_value;
      end
      w.adc_value = 10'(v);
    end
    return w;
  endfunction

  task automatic send_word(input rlps_pkg::in_word_t w);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_lights.push_back(predict_tick(w));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_lights.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input rlps_pkg::cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      rlps_pkg::CFG_DEBOUNCE:  debounce_cfg = value;
      rlps_pkg::CFG_PAUSE_MIN: pause_lo_cfg = value[8:0];
      rlps_pkg::CFG_PAUSE_MAX: pause_hi_cfg = value[8:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] debounce, input logic [8:0] lo,
                            input logic [8:0] hi);
    drain();
    write_reg(rlps_pkg::CFG_DEBOUNCE, debounce);
    write_reg(rlps_pkg::CFG_PAUSE_MIN, {7'd0, lo});
    write_reg(rlps_pkg::CFG_PAUSE_MAX, {7'd0, hi});
  endtask

  task automatic run_random(input int count, input int press_pct);
    repeat (count) send_word(random_tick(press_pct));
  endtask

  task automatic test_directed();
    // reset settings: dark before any sample, press inside debounce window
    send_word(make_word(0, 1, 0, 0));
    send_word(make_word(1, 0, 0, 0));
    send_word(make_word(0, 1, 1, 1023));
    set_config(16'd0, 9'd0, 9'd511);
    send_word(make_word(0, 1, 1, 0));
    send_word(make_word(1, 1, 1, 5));
    repeat (5) send_word(make_word(1, 1, 0, 0));
    send_word(make_word(0, 1, 1, 1023));
    send_word(make_word(0, 1, 1, 1020));
    send_word(make_word(0, 1, 0, 0));
    send_word(make_word(0, 1, 0, 0));
    send_word(make_word(1, 0, 0, 0));
    send_word(make_word(0, 0, 0, 0));
    send_word(make_word(0, 1, 0, 0));
    send_word(make_word(0, 1, 0, 0));
    send_word(make_word(1, 1, 1, 512));
    send_word(make_word(0, 1, 0, 0));
    send_word(make_word(0, 1, 0, 0));
    send_word(make_word(1, 1, 1, 511));
  endtask

  task automatic test_fast_cycle();
    set_config(16'd0, 9'd0, 9'd0);
    run_random(500, 8);
  endtask

  task automatic test_long_pauses();
    set_config(16'hFFFF, 9'd511, 9'd511);
    run_random(200, 5);
  endtask

  task automatic test_reversed_range();
    set_config(16'd3, 9'd400, 9'd7);
    run_random(350, 4);
  endtask

  task automatic test_backpressure();
    set_config(16'd10, 9'd2, 9'd40);
    hold_off_left = 400;
    run_random(150, 6);
    drain();
    run_random(50, 6);
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    run_random(350, 6);
    steady = 1'b0;
  endtask

  task automatic test_wide_range();
    set_config(16'd30, 9'd0, 9'd511);
    run_random(350, 5);
  endtask

  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    rlps_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lights.size() == 0) begin
        $error("unexpected word: mode %0d", out_word_o.light_mode);
        mismatches++;
      end else begin
        want = expected_lights.pop_front();
        if (out_word_o.red_duty !== want.red_duty) begin
          $error("red_duty: expected %0d, got %0d", want.red_duty, out_word_o.red_duty);
          mismatches++;
        end
        if (out_word_o.green_duty !== want.green_duty) begin
          $error("green_duty: expected %0d, got %0d", want.green_duty,
                 out_word_o.green_duty);
          mismatches++;
        end
        if (out_word_o.blue_duty !== want.blue_duty) begin
          $error("blue_duty: expected %0d, got %0d", want.blue_duty, out_word_o.blue_duty);
          mismatches++;
        end
        if (out_word_o.light_mode !== want.light_mode) begin
          $error("light_mode: expected %0d, got %0d", want.light_mode,
                 out_word_o.light_mode);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_sequencer();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fast_cycle();
    test_long_pauses();
    test_reversed_range();
    test_backpressure();
    test_steady_stream();
    test_wide_range();
    drain();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rlps_pkg.sv
sv/rlps_knob.sv
sv/rlps_seq.sv
sv/rgb_light_pattern_sequencer.sv
tb/testbench.sv
